// ===== sv/thtk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thtk_pkg: shared types and constants for threshold top-k dropping
// item formats, kept entry, scan token, cell control and controller states
// ----------------------------------------------------------------------------
package thtk_pkg;

  // slot and count widths cover the largest store of 64 entries
  localparam int SLOT_W = 6;
  localparam int CNT_W  = 7;
  localparam int POS_W  = 10;
  localparam int MAG_W  = 32;

  // configuration register indexes
  localparam logic [1:0] REG_FILL_LIMIT = 2'd0;
  localparam logic [1:0] REG_THRESHOLD  = 2'd1;
  localparam logic [1:0] REG_DIAG_INDEX = 2'd2;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } thtk_in_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [MAG_W-1:0] magnitude;
    logic             valid_res;
    logic             is_last;
  } thtk_out_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic [POS_W-1:0] pos;
    logic             diag;
  } thtk_entry_t;

  // weakest-entry search token walking down the chain
  typedef struct packed {
    logic              active;
    logic              found;
    logic [MAG_W-1:0]  mag;
    logic [SLOT_W-1:0] slot;
  } thtk_tok_t;

  // broadcast control to every cell
  typedef struct packed {
    logic              wr_en;
    logic [SLOT_W-1:0] wr_slot;
    thtk_entry_t       wr_entry;
    logic              sh_en;
    logic [SLOT_W-1:0] sh_from;
    logic [CNT_W-1:0]  count;
  } thtk_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } thtk_state_t;

endpackage

// ===== sv/thtk_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thtk_cell: one slot of the kept-entry chain
// holds one entry, shifts from its right neighbor and updates the scan token
// ----------------------------------------------------------------------------
module thtk_cell import thtk_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic        clk,
  input  logic        rst,
  input  thtk_ctrl_t  ctrl,
  input  thtk_entry_t right_in,
  output thtk_entry_t ent,
  input  thtk_tok_t   tok_in,
  output thtk_tok_t   tok_out
);

  localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX);

  logic      elig;
  logic      take;
  thtk_tok_t tok_next;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en && ctrl.wr_slot == MY_SLOT) begin
      ent <= ctrl.wr_entry;
    end else if (ctrl.sh_en && MY_SLOT >= ctrl.sh_from) begin
      ent <= right_in;
    end
  end

  // later slot wins a tie on magnitude
  assign elig = (CNT_W'(IDX) < ctrl.count) && !ent.diag;
  assign take = tok_in.active && elig && (!tok_in.found || ent.mag <= tok_in.mag);

  always_comb begin
    tok_next        = tok_in;
    tok_next.found  = tok_in.found | take;
    tok_next.mag    = take ? ent.mag : tok_in.mag;
    tok_next.slot   = take ? MY_SLOT : tok_in.slot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

// ===== sv/threshold_topk_drop_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// threshold_topk_drop_top: dual-threshold dropping of one sparse row
// keeps above-threshold entries and the diagonal, at most fill_limit of them
// ----------------------------------------------------------------------------
// Row elements come in one item per start pulse, element k at position k. An
// item that is dropped or simply appended to the store leaves busy low unless
// it is marked last, so such items can follow back to back. A candidate that
// meets a full store launches a weakest-entry search down the chain of
// MAX_FILL cells, one cell per cycle, and busy stays high until the search
// has passed the last cell. After the item marked last the kept entries
// shift out of cell 0, one result per cycle in ascending position order:
// once that item is taken, or once its search ends when it met a full store,
// the state register enters the drain state, and res_strobe and res_item are
// registered from it. busy stays high while the row drains, and a row that
// kept nothing gives one result with valid_res low. The receiver cannot
// stall: every result is shown for exactly one cycle under res_strobe. No
// clearing pass is needed after reset. The user must write configuration only
// while busy is low and no results are pending; the block does not enforce it.
// ----------------------------------------------------------------------------
module threshold_topk_drop_top import thtk_pkg::*; #(
  parameter int MAX_LEN  = 1024,
  parameter int MAX_FILL = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  thtk_in_t    in_item,
  output logic        res_strobe,
  output thtk_out_t   res_item,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [30:0] cfg_wdata
);

  localparam int CTR_W = $clog2(MAX_LEN + 1);

  // configuration
  logic [6:0]         fill_limit;
  logic [30:0]        threshold;
  logic signed [10:0] diag_index;

  // row state
  thtk_state_t      state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CTR_W-1:0] counter, counter_next;
  thtk_entry_t      pend;
  logic             pend_last;

  // chain
  thtk_ctrl_t  ctrl;
  thtk_entry_t ents [MAX_FILL];
  thtk_tok_t   toks [MAX_FILL+1];

  // item decode
  logic             accept;
  logic [31:0]      v_raw;
  logic [31:0]      mag;
  logic             in_range;
  logic             is_diag;
  logic             cand;
  logic [6:0]       lim7;
  logic [CNT_W-1:0] lim;
  logic             do_append;
  logic             need_scan;
  thtk_entry_t      new_entry;
  logic             scan_done;
  logic             replace;
  thtk_out_t        res_next;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_limit <= 7'd64;
      threshold  <= '0;
      diag_index <= -11'sd1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FILL_LIMIT: fill_limit <= cfg_wdata[6:0];
        REG_THRESHOLD:  threshold  <= cfg_wdata;
        REG_DIAG_INDEX: diag_index <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  // magnitude of the incoming value, -2^31 maps to 2^31
  assign v_raw    = in_item.value;
  assign mag      = v_raw[31] ? (~v_raw + 32'd1) : v_raw;
  assign in_range = (32'(counter) < 32'(MAX_LEN));
  assign is_diag  = in_range && !diag_index[10] &&
                    (32'(counter) == 32'(diag_index[9:0]));
  assign cand     = in_range && ((mag > {1'b0, threshold}) || is_diag);

  // limits above the store size act as the store size
  assign lim7 = (fill_limit > 7'(MAX_FILL)) ? 7'(MAX_FILL) : fill_limit;
  assign lim  = CNT_W'(lim7);

  assign do_append = cand && (count < lim);
  assign need_scan = cand && !(count < lim) && (count != '0) && (lim != '0);

  assign new_entry.mag  = mag;
  assign new_entry.pos  = POS_W'(counter);
  assign new_entry.diag = is_diag;

  // position counter saturates at the row length limit
  always_comb begin
    if (in_item.last) begin
      counter_next = '0;
    end else if (in_range) begin
      counter_next = counter + CTR_W'(1);
    end else begin
      counter_next = counter;
    end
  end

  // search result arrives after the token passes the last cell
  assign scan_done = toks[MAX_FILL].active;
  assign replace   = toks[MAX_FILL].found && (pend.diag || pend.mag > toks[MAX_FILL].mag);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (need_scan) begin
            state_next = ST_SCAN;
          end else if (in_item.last) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = pend_last ? ST_DRAIN : ST_IDLE;
        end
      end
      ST_DRAIN: begin
        if (count <= CNT_W'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // chain control and count update
  always_comb begin
    ctrl          = '0;
    ctrl.count    = count;
    ctrl.wr_entry = new_entry;
    count_next    = count;
    toks[0]       = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept && do_append) begin
          ctrl.wr_en   = 1'b1;
          ctrl.wr_slot = SLOT_W'(count);
          count_next   = count + CNT_W'(1);
        end
        toks[0].active = accept && need_scan;
      end
      ST_SCAN: begin
        // on a replace, drop the weakest, close the gap, new entry goes to the tail
        ctrl.wr_entry = pend;
        if (scan_done && replace) begin
          ctrl.wr_en   = 1'b1;
          ctrl.wr_slot = SLOT_W'(count - CNT_W'(1));
          ctrl.sh_en   = 1'b1;
          ctrl.sh_from = toks[MAX_FILL].slot;
        end
      end
      ST_DRAIN: begin
        if (count != '0) begin
          ctrl.sh_en   = 1'b1;
          ctrl.sh_from = '0;
          count_next   = count - CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // result from the head cell, or the empty row marker
  always_comb begin
    if (count == '0) begin
      res_next.position  = '0;
      res_next.magnitude = '0;
      res_next.valid_res = 1'b0;
      res_next.is_last   = 1'b1;
    end else begin
      res_next.position  = ents[0].pos;
      res_next.magnitude = ents[0].mag;
      res_next.valid_res = 1'b1;
      res_next.is_last   = (count == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      counter    <= '0;
      res_strobe <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      res_strobe <= (state == ST_DRAIN);
      if (accept) begin
        counter <= counter_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      pend      <= new_entry;
      pend_last <= in_item.last;
    end
    res_item <= res_next;
  end

  // row of cells, slot 0 at the head
  for (genvar k = 0; k < MAX_FILL; k++) begin : g_cell
    thtk_entry_t right_in;
    if (k == MAX_FILL - 1) begin : g_tail
      assign right_in = '0;
    end else begin : g_mid
      assign right_in = ents[k+1];
    end
    thtk_cell #(
      .IDX (k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .right_in (right_in),
      .ent      (ents[k]),
      .tok_in   (toks[k]),
      .tok_out  (toks[k+1])
    );
  end

endmodule

// ===== sv/thtk_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thtk_checker: port-level checks for threshold top-k dropping
// result framing of a row, bound to the top level
// ----------------------------------------------------------------------------
module thtk_checker import thtk_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      busy,
  input logic      res_strobe,
  input thtk_out_t res_item
);

  // an empty row marker is always the final item
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    res_strobe && !res_item.valid_res |-> res_item.is_last)
    else $error("empty row result without is_last");

  // a row's results come in consecutive cycles
  a_row_contiguous: assert property (@(posedge clk) disable iff (rst)
    res_strobe && !res_item.is_last |=> res_strobe)
    else $error("gap inside a row of results");

  // the next row cannot start emitting right after a final result
  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    res_strobe && res_item.is_last |=> !res_strobe)
    else $error("result right after the final result of a row");

  // no new item is taken while a row is still being emitted
  a_busy_mid_row: assert property (@(posedge clk) disable iff (rst)
    res_strobe && !res_item.is_last |-> busy)
    else $error("not busy while results are still pending");

endmodule

bind threshold_topk_drop_top thtk_checker u_thtk_checker (
  .clk        (clk),
  .rst        (rst),
  .busy       (busy),
  .res_strobe (res_strobe),
  .res_item   (res_item)
);
